@@ hw/rtl/rlkdr_pkg.sv @@
// Shared types, constants and register codes for the resistor-ladder key debounce block.
package rlkdr_pkg;

    localparam int LINE_COUNT  = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int LINE_W      = 2;
    localparam int LIDX_W      = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int ZONE_W      = 2;
    localparam int KIND_W      = 2;
    localparam int TICK_W      = 32;
    localparam int THR_W       = 12;
    localparam int CMP_W       = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int CNT_W       = 8;
    localparam int DUR_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NONE_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd6;

    // Register reset values
    localparam logic [THR_W-1:0] RST_NONE_THR  = 12'd3800;
    localparam logic [THR_W-1:0] RST_UPPER_THR = 12'd2500;
    localparam logic [THR_W-1:0] RST_LOWER_THR = 12'd1000;
    localparam logic [CNT_W-1:0] RST_STABLE    = 8'd3;
    localparam logic [DUR_W-1:0] RST_LONG      = 16'd1000;
    localparam logic [DUR_W-1:0] RST_HOLD      = 16'd500;
    localparam logic [DUR_W-1:0] RST_REPEAT    = 16'd150;

    // Zone codes
    localparam logic [ZONE_W-1:0] ZONE_NONE  = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_LOW   = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_MID   = 2'd2;
    localparam logic [ZONE_W-1:0] ZONE_HIGH  = 2'd3;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_PRESS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;

    // Select key: control line, middle zone
    localparam logic [LINE_W-1:0] SEL_LINE = 2'd0;
    localparam logic [ZONE_W-1:0] SEL_ZONE = ZONE_MID;

    typedef struct packed {
        logic [THR_W-1:0] none_thr;
        logic [THR_W-1:0] upper_thr;
        logic [THR_W-1:0] lower_thr;
    } thr_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] stable_count;
        logic [DUR_W-1:0] long_ticks;
        logic [DUR_W-1:0] hold_ticks;
        logic [DUR_W-1:0] repeat_ticks;
    } tim_cfg_t;

    // Classified request passed from front to back
    typedef struct packed {
        logic [LIDX_W-1:0] line;
        logic [ZONE_W-1:0] zone;
        logic [TICK_W-1:0] tick;
    } item_t;

endpackage

@@ hw/rtl/rlkdr_front.sv @@
// Front end: accept sample requests, drop invalid lines and classify into zones.
module rlkdr_front (
    input  logic [rlkdr_pkg::LINE_W-1:0]      s_line_index,
    input  logic [rlkdr_pkg::SAMPLE_BITS-1:0] s_adc_sample,
    input  logic [rlkdr_pkg::TICK_W-1:0]      s_now_tick,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rlkdr_pkg::thr_cfg_t               thr_cfg,
    input  logic                              q_full,
    output logic                              push,
    output rlkdr_pkg::item_t                  push_item
);

    logic                             line_ok;
    logic [rlkdr_pkg::ZONE_W-1:0]     zone;
    logic [rlkdr_pkg::CMP_W-1:0]      smp;

    assign s_ready = !q_full;
    assign smp     = rlkdr_pkg::CMP_W'(s_adc_sample);
    assign line_ok = (32'(s_line_index) < rlkdr_pkg::LINE_COUNT);

    // Classify in the fixed order none, upper, lower
    always_comb begin
        if (smp >= rlkdr_pkg::CMP_W'(thr_cfg.none_thr)) begin
            zone = rlkdr_pkg::ZONE_NONE;
        end else if (smp >= rlkdr_pkg::CMP_W'(thr_cfg.upper_thr)) begin
            zone = rlkdr_pkg::ZONE_HIGH;
        end else if (smp >= rlkdr_pkg::CMP_W'(thr_cfg.lower_thr)) begin
            zone = rlkdr_pkg::ZONE_MID;
        end else begin
            zone = rlkdr_pkg::ZONE_LOW;
        end
    end

    // Queue only requests on an existing line
    assign push           = s_valid && s_ready && line_ok;
    assign push_item.line = rlkdr_pkg::LIDX_W'(s_line_index);
    assign push_item.zone = zone;
    assign push_item.tick = s_now_tick;

endmodule

@@ hw/rtl/rlkdr_queue.sv @@
// Short request queue between the classifying front and the debounce back end.
module rlkdr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rlkdr_pkg::item_t push_item,
    input  logic             pop,
    output rlkdr_pkg::item_t pop_item,
    output logic             not_empty,
    output logic             full
);

    rlkdr_pkg::item_t                  entry_reg [rlkdr_pkg::Q_DEPTH];
    logic [rlkdr_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rlkdr_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rlkdr_pkg::Q_CNT_W-1:0]     count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (32'(count_reg) == rlkdr_pkg::Q_DEPTH);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued requests
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/rlkdr_back.sv @@
// Back end: per-line debounce, press, auto-repeat and long-press events with output register.
module rlkdr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rlkdr_pkg::tim_cfg_t           tim_cfg,
    input  logic                          q_not_empty,
    input  rlkdr_pkg::item_t              q_item,
    output logic                          pop,
    output logic [rlkdr_pkg::LINE_W-1:0]  m_event_line,
    output logic [rlkdr_pkg::ZONE_W-1:0]  m_event_zone,
    output logic [rlkdr_pkg::KIND_W-1:0]  m_event_kind,
    output logic                          m_valid,
    input  logic                          m_ready
);

    // Per-line state
    logic [rlkdr_pkg::ZONE_W-1:0] stab_reg  [rlkdr_pkg::LINE_COUNT];
    logic [rlkdr_pkg::ZONE_W-1:0] cand_reg  [rlkdr_pkg::LINE_COUNT];
    logic [rlkdr_pkg::CNT_W-1:0]  cnt_reg   [rlkdr_pkg::LINE_COUNT];
    logic [rlkdr_pkg::TICK_W-1:0] press_reg [rlkdr_pkg::LINE_COUNT];
    logic [rlkdr_pkg::TICK_W-1:0] rep_reg   [rlkdr_pkg::LINE_COUNT];
    logic                         long_reg  [rlkdr_pkg::LINE_COUNT];

    logic [rlkdr_pkg::ZONE_W-1:0] stab_next, cand_next;
    logic [rlkdr_pkg::CNT_W-1:0]  cnt_next;
    logic [rlkdr_pkg::TICK_W-1:0] press_next, rep_next;
    logic                         long_next;
    logic                         event_hit;
    logic [rlkdr_pkg::KIND_W-1:0] event_kind;

    logic [rlkdr_pkg::LIDX_W-1:0] ln;
    logic [rlkdr_pkg::ZONE_W-1:0] stab, cand;
    logic [rlkdr_pkg::CNT_W-1:0]  cnt;
    logic [rlkdr_pkg::TICK_W-1:0] held, since_rep;
    logic                         is_select;

    logic                         valid_reg;
    logic [rlkdr_pkg::LINE_W-1:0] line_reg;
    logic [rlkdr_pkg::ZONE_W-1:0] zone_reg;
    logic [rlkdr_pkg::KIND_W-1:0] kind_reg;

    assign ln        = q_item.line;
    assign stab      = stab_reg[ln];
    assign cand      = cand_reg[ln];
    assign cnt       = cnt_reg[ln];
    assign held      = q_item.tick - press_reg[ln];
    assign since_rep = q_item.tick - rep_reg[ln];
    assign is_select = (rlkdr_pkg::LINE_W'(ln) == rlkdr_pkg::SEL_LINE)
                       && (stab == rlkdr_pkg::SEL_ZONE);

    // Take the next request whenever the output register is free or drains
    assign pop = q_not_empty && (!valid_reg || m_ready);

    // Debounce the zone and decide the event
    always_comb begin
        stab_next  = stab;
        cand_next  = cand;
        cnt_next   = cnt;
        press_next = press_reg[ln];
        rep_next   = rep_reg[ln];
        long_next  = long_reg[ln];
        event_hit  = 1'b0;
        event_kind = rlkdr_pkg::KIND_PRESS;

        if (q_item.zone == cand) begin
            if (cnt < tim_cfg.stable_count) begin
                cnt_next = cnt + 1'b1;
            end
        end else begin
            cand_next = q_item.zone;
            cnt_next  = '0;
        end

        if ((cnt_next >= tim_cfg.stable_count) && (cand_next != stab)) begin
            stab_next = cand_next;
            if (cand_next != rlkdr_pkg::ZONE_NONE) begin
                press_next = q_item.tick;
                rep_next   = q_item.tick;
                long_next  = 1'b0;
                event_hit  = 1'b1;
                event_kind = rlkdr_pkg::KIND_PRESS;
            end
        end else if ((stab != rlkdr_pkg::ZONE_NONE) && (cand_next == stab)) begin
            if (is_select) begin
                if (!long_reg[ln] && (held >= rlkdr_pkg::TICK_W'(tim_cfg.long_ticks))) begin
                    long_next  = 1'b1;
                    event_hit  = 1'b1;
                    event_kind = rlkdr_pkg::KIND_LONG;
                end
            end else if ((held >= rlkdr_pkg::TICK_W'(tim_cfg.hold_ticks))
                         && (since_rep >= rlkdr_pkg::TICK_W'(tim_cfg.repeat_ticks))) begin
                rep_next   = q_item.tick;
                event_hit  = 1'b1;
                event_kind = rlkdr_pkg::KIND_REPEAT;
            end
        end
    end

    // Update the state of the line in hand
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rlkdr_pkg::LINE_COUNT; i++) begin
                stab_reg[i]  <= rlkdr_pkg::ZONE_NONE;
                cand_reg[i]  <= rlkdr_pkg::ZONE_NONE;
                cnt_reg[i]   <= '0;
                press_reg[i] <= '0;
                rep_reg[i]   <= '0;
                long_reg[i]  <= 1'b0;
            end
        end else if (pop) begin
            stab_reg[ln]  <= stab_next;
            cand_reg[ln]  <= cand_next;
            cnt_reg[ln]   <= cnt_next;
            press_reg[ln] <= press_next;
            rep_reg[ln]   <= rep_next;
            long_reg[ln]  <= long_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= event_hit;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            line_reg <= rlkdr_pkg::LINE_W'(ln);
            zone_reg <= stab_next;
            kind_reg <= event_kind;
        end
    end

    assign m_valid      = valid_reg;
    assign m_event_line = line_reg;
    assign m_event_zone = zone_reg;
    assign m_event_kind = kind_reg;

endmodule

@@ hw/rtl/resistor_ladder_key_debounce_repeat.sv @@
// Accepted requests are queued; the output register takes a result when its request is popped.
// Throughput: one sample request per cycle while the queue is not full; the back end retires one
// queued request each cycle while the output register is empty or its result is being taken.
// A four-entry request queue sits between classification and the per-line state update.
// Reset (aresetn low, synchronous): registers return to their defaults, all per-line state
// clears to no key, the queue empties and no result is shown.
module resistor_ladder_key_debounce_repeat (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [rlkdr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rlkdr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [rlkdr_pkg::LINE_W-1:0]          s_line_index,
    input  logic [rlkdr_pkg::SAMPLE_BITS-1:0]     s_adc_sample,
    input  logic [rlkdr_pkg::TICK_W-1:0]          s_now_tick,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [rlkdr_pkg::LINE_W-1:0]          m_event_line,
    output logic [rlkdr_pkg::ZONE_W-1:0]          m_event_zone,
    output logic [rlkdr_pkg::KIND_W-1:0]          m_event_kind
);

    rlkdr_pkg::thr_cfg_t thr_cfg_reg;
    rlkdr_pkg::tim_cfg_t tim_cfg_reg;

    logic             q_full;
    logic             q_not_empty;
    logic             push;
    logic             pop;
    rlkdr_pkg::item_t push_item;
    rlkdr_pkg::item_t pop_item;

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_cfg_reg.none_thr     <= rlkdr_pkg::RST_NONE_THR;
            thr_cfg_reg.upper_thr    <= rlkdr_pkg::RST_UPPER_THR;
            thr_cfg_reg.lower_thr    <= rlkdr_pkg::RST_LOWER_THR;
            tim_cfg_reg.stable_count <= rlkdr_pkg::RST_STABLE;
            tim_cfg_reg.long_ticks   <= rlkdr_pkg::RST_LONG;
            tim_cfg_reg.hold_ticks   <= rlkdr_pkg::RST_HOLD;
            tim_cfg_reg.repeat_ticks <= rlkdr_pkg::RST_REPEAT;
        end else if (cfg_we) begin
            case (cfg_index)
                rlkdr_pkg::REG_NONE_THR: begin
                    thr_cfg_reg.none_thr <= rlkdr_pkg::THR_W'(cfg_wdata);
                end
                rlkdr_pkg::REG_UPPER_THR: begin
                    thr_cfg_reg.upper_thr <= rlkdr_pkg::THR_W'(cfg_wdata);
                end
                rlkdr_pkg::REG_LOWER_THR: begin
                    thr_cfg_reg.lower_thr <= rlkdr_pkg::THR_W'(cfg_wdata);
                end
                rlkdr_pkg::REG_STABLE: begin
                    tim_cfg_reg.stable_count <= rlkdr_pkg::CNT_W'(cfg_wdata);
                end
                rlkdr_pkg::REG_LONG: begin
                    tim_cfg_reg.long_ticks <= rlkdr_pkg::DUR_W'(cfg_wdata);
                end
                rlkdr_pkg::REG_HOLD: begin
                    tim_cfg_reg.hold_ticks <= rlkdr_pkg::DUR_W'(cfg_wdata);
                end
                rlkdr_pkg::REG_REPEAT: begin
                    tim_cfg_reg.repeat_ticks <= rlkdr_pkg::DUR_W'(cfg_wdata);
                end
                default: begin
                end
            endcase
        end
    end

    rlkdr_front u_front (
        .s_line_index (s_line_index),
        .s_adc_sample (s_adc_sample),
        .s_now_tick   (s_now_tick),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .thr_cfg      (thr_cfg_reg),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    rlkdr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    rlkdr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tim_cfg      (tim_cfg_reg),
        .q_not_empty  (q_not_empty),
        .q_item       (pop_item),
        .pop          (pop),
        .m_event_line (m_event_line),
        .m_event_zone (m_event_zone),
        .m_event_kind (m_event_kind),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule

@@ bench/rlkdr_event_checker.sv @@
// Key event checker: mirrors the debounce state per line, predicts events and compares them.
`timescale 1ns / 1ps
module rlkdr_event_checker
    import rlkdr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [LINE_W-1:0]      s_line_index,
    input  logic [SAMPLE_BITS-1:0] s_adc_sample,
    input  logic [TICK_W-1:0]      s_now_tick,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [LINE_W-1:0]      m_event_line,
    input  logic [ZONE_W-1:0]      m_event_zone,
    input  logic [KIND_W-1:0]      m_event_kind,
    output int unsigned            err_count,
    output int unsigned            events_due
);

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [ZONE_W-1:0] zone;
        logic [KIND_W-1:0] kind;
    } key_event_t;

    // Shadow copy of the registers
    logic [THR_W-1:0] none_thr;
    logic [THR_W-1:0] upper_thr;
    logic [THR_W-1:0] lower_thr;
    logic [CNT_W-1:0] settle_need;
    logic [DUR_W-1:0] long_need;
    logic [DUR_W-1:0] hold_need;
    logic [DUR_W-1:0] repeat_gap;

    // Per-line debounce and hold state
    logic [ZONE_W-1:0] held_zone   [LINE_COUNT];
    logic [ZONE_W-1:0] seen_zone   [LINE_COUNT];
    logic [CNT_W-1:0]  seen_run    [LINE_COUNT];
    logic [TICK_W-1:0] pressed_at  [LINE_COUNT];
    logic [TICK_W-1:0] repeated_at [LINE_COUNT];
    logic              long_sent   [LINE_COUNT];

    key_event_t events_owed[$];

    // Classify a sample; the compares run in fixed order whatever the thresholds are
    function automatic logic [ZONE_W-1:0] zone_for(input logic [SAMPLE_BITS-1:0] smp);
        if (CMP_W'(smp) >= CMP_W'(none_thr)) return ZONE_NONE;
        if (CMP_W'(smp) >= CMP_W'(upper_thr)) return ZONE_HIGH;
        if (CMP_W'(smp) >= CMP_W'(lower_thr)) return ZONE_MID;
        return ZONE_LOW;
    endfunction

    // Advance one line by one sample; return 1 when the sample raises a key event
    function automatic bit debounce_step(input logic [LINE_W-1:0] ln,
                                         input logic [SAMPLE_BITS-1:0] smp,
                                         input logic [TICK_W-1:0] now,
                                         output key_event_t ev);
        logic [ZONE_W-1:0] z;
        logic [TICK_W-1:0] held_for;
        logic [TICK_W-1:0] since_repeat;
        bit                fired;
        ev = '0;
        fired = 1'b0;
        if (int'(ln) >= LINE_COUNT) return 1'b0;
        z = zone_for(smp);

        // count equal samples, saturating at the current setting
        if (z == seen_zone[ln]) begin
            if (seen_run[ln] < settle_need) seen_run[ln] = seen_run[ln] + 1'b1;
        end else begin
            seen_zone[ln] = z;
            seen_run[ln] = '0;
        end

        if (seen_run[ln] >= settle_need && seen_zone[ln] != held_zone[ln]) begin
            // accept the change; a release updates the key only
            held_zone[ln] = seen_zone[ln];
            if (held_zone[ln] != ZONE_NONE) begin
                pressed_at[ln] = now;
                repeated_at[ln] = now;
                long_sent[ln] = 1'b0;
                ev.kind = KIND_PRESS;
                fired = 1'b1;
            end
        end else if (held_zone[ln] != ZONE_NONE && seen_zone[ln] == held_zone[ln]) begin
            // key held: select fires one long press, the rest auto-repeat
            held_for = now - pressed_at[ln];
            since_repeat = now - repeated_at[ln];
            if (ln == SEL_LINE && held_zone[ln] == SEL_ZONE) begin
                if (!long_sent[ln] && held_for >= TICK_W'(long_need)) begin
                    long_sent[ln] = 1'b1;
                    ev.kind = KIND_LONG;
                    fired = 1'b1;
                end
            end else if (held_for >= TICK_W'(hold_need)
                         && since_repeat >= TICK_W'(repeat_gap)) begin
                repeated_at[ln] = now;
                ev.kind = KIND_REPEAT;
                fired = 1'b1;
            end
        end
        ev.line = ln;
        ev.zone = held_zone[ln];
        return fired;
    endfunction

    always @(posedge aclk) begin
        key_event_t ev;
        key_event_t want;
        if (!aresetn) begin
            none_thr = RST_NONE_THR;
            upper_thr = RST_UPPER_THR;
            lower_thr = RST_LOWER_THR;
            settle_need = RST_STABLE;
            long_need = RST_LONG;
            hold_need = RST_HOLD;
            repeat_gap = RST_REPEAT;
            for (int i = 0; i < LINE_COUNT; i++) begin
                held_zone[i] = ZONE_NONE;
                seen_zone[i] = ZONE_NONE;
                seen_run[i] = '0;
                pressed_at[i] = '0;
                repeated_at[i] = '0;
                long_sent[i] = 1'b0;
            end
            events_owed.delete();
        end else begin
            // track register writes; unknown indexes fall through
            if (cfg_we) begin
                case (cfg_index)
                    REG_NONE_THR:  none_thr = cfg_wdata[THR_W-1:0];
                    REG_UPPER_THR: upper_thr = cfg_wdata[THR_W-1:0];
                    REG_LOWER_THR: lower_thr = cfg_wdata[THR_W-1:0];
                    REG_STABLE:    settle_need = cfg_wdata[CNT_W-1:0];
                    REG_LONG:      long_need = cfg_wdata[DUR_W-1:0];
                    REG_HOLD:      hold_need = cfg_wdata[DUR_W-1:0];
                    REG_REPEAT:    repeat_gap = cfg_wdata[DUR_W-1:0];
                    default: ;
                endcase
            end

            // predict on each accepted sample request
            if (s_valid && s_ready) begin
                if (debounce_step(s_line_index, s_adc_sample, s_now_tick, ev))
                    events_owed.push_back(ev);
            end

            // compare each delivered event with the oldest prediction
            if (m_valid && m_ready) begin
                if (events_owed.size() == 0) begin
                    $display("%0t: event expected none, actual line %0d zone %0d kind %0d",
                             $time, m_event_line, m_event_zone, m_event_kind);
                    err_count = err_count + 1;
                end else begin
                    want = events_owed.pop_front();
                    if (m_event_line !== want.line) begin
                        $display("%0t: event_line expected %0d actual %0d",
                                 $time, want.line, m_event_line);
                        err_count = err_count + 1;
                    end
                    if (m_event_zone !== want.zone) begin
                        $display("%0t: event_zone expected %0d actual %0d",
                                 $time, want.zone, m_event_zone);
                        err_count = err_count + 1;
                    end
                    if (m_event_kind !== want.kind) begin
                        $display("%0t: event_kind expected %0d actual %0d",
                                 $time, want.kind, m_event_kind);
                        err_count = err_count + 1;
                    end
                end
            end
        end
        events_due = events_owed.size();
    end

endmodule

@@ bench/tb_resistor_ladder_key_debounce_repeat.sv @@
// Bench top for the key debounce block: clock, reset, sample and event traffic, verdict.
`timescale 1ns / 1ps
module tb_resistor_ladder_key_debounce_repeat;
    import rlkdr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [LINE_W-1:0]      s_line_index = '0;
    logic [SAMPLE_BITS-1:0] s_adc_sample = '0;
    logic [TICK_W-1:0]      s_now_tick = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [LINE_W-1:0]      m_event_line;
    logic [ZONE_W-1:0]      m_event_zone;
    logic [KIND_W-1:0]      m_event_kind;

    int unsigned err_count;
    int unsigned events_due;

    // Stimulus-side view of the settings, used to aim samples at zones
    logic [THR_W-1:0] none_thr = RST_NONE_THR;
    logic [THR_W-1:0] upper_thr = RST_UPPER_THR;
    logic [THR_W-1:0] lower_thr = RST_LOWER_THR;
    logic [CNT_W-1:0] settle_need = RST_STABLE;
    logic [TICK_W-1:0] tick_now = '0;

    bit steady = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    resistor_ladder_key_debounce_repeat u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_line_index (s_line_index),
        .s_adc_sample (s_adc_sample),
        .s_now_tick   (s_now_tick),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_line (m_event_line),
        .m_event_zone (m_event_zone),
        .m_event_kind (m_event_kind)
    );

    rlkdr_event_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_line_index (s_line_index),
        .s_adc_sample (s_adc_sample),
        .s_now_tick   (s_now_tick),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_line (m_event_line),
        .m_event_zone (m_event_zone),
        .m_event_kind (m_event_kind),
        .err_count    (err_count),
        .events_due   (events_due)
    );

    // Event receiver: random stalls, quiet stretches and one long hold-off on request
    initial begin
        int unsigned held;
        held = 0;
        forever begin
            @(negedge aclk);
            if (held != 0) begin
                held = held - 1;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                held = HOLD_OFF_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 8);
            end
        end
    end

    // Offer one sample request and hold it until taken; entered and left at a falling edge
    task automatic put_sample(input logic [LINE_W-1:0] line,
                              input logic [SAMPLE_BITS-1:0] smp,
                              input logic [TICK_W-1:0] tick);
        while (!steady && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_line_index <= line;
        s_adc_sample <= smp;
        s_now_tick <= tick;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    // Write every register back to back, with junk in the unused upper bits
    task automatic apply_settings(input logic [THR_W-1:0] n, input logic [THR_W-1:0] u,
                                  input logic [THR_W-1:0] l, input logic [CNT_W-1:0] st,
                                  input logic [DUR_W-1:0] lp, input logic [DUR_W-1:0] hd,
                                  input logic [DUR_W-1:0] rp);
        write_reg(REG_NONE_THR, {4'($urandom), n});
        write_reg(REG_UPPER_THR, {4'($urandom), u});
        write_reg(REG_LOWER_THR, {4'($urandom), l});
        write_reg(REG_STABLE, {8'($urandom), st});
        write_reg(REG_LONG, lp);
        write_reg(REG_HOLD, hd);
        write_reg(REG_REPEAT, rp);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        none_thr = n;
        upper_thr = u;
        lower_thr = l;
        settle_need = st;
    endtask

    // Pick a sample that lands in the given zone, or any sample if the zone is empty
    function automatic logic [SAMPLE_BITS-1:0] sample_for(input logic [ZONE_W-1:0] zone);
        int n, u, l, lo, hi;
        n = int'(none_thr);
        u = (int'(upper_thr) < n) ? int'(upper_thr) : n;
        l = (int'(lower_thr) < u) ? int'(lower_thr) : u;
        case (zone)
            ZONE_NONE: begin lo = n;                hi = SAMPLE_MAX; end
            ZONE_HIGH: begin lo = int'(upper_thr);  hi = n - 1;      end
            ZONE_MID:  begin lo = int'(lower_thr);  hi = u - 1;      end
            default:   begin lo = 0;                hi = l - 1;      end
        endcase
        if (hi < lo) return SAMPLE_BITS'($urandom);
        return SAMPLE_BITS'($urandom_range(hi, lo));
    endfunction

    // Mostly held keys of random zone and length, with bounces and raw noise mixed in
    task automatic key_runs(input int unsigned n_items, input int unsigned step_max);
        int unsigned sent, run;
        logic [LINE_W-1:0] line;
        logic [ZONE_W-1:0] zone;
        logic [SAMPLE_BITS-1:0] smp;
        sent = 0;
        while (sent < n_items) begin
            line = LINE_W'($urandom);
            if ($urandom_range(9) == 0) begin
                tick_now = tick_now + TICK_W'($urandom_range(step_max));
                put_sample(line, SAMPLE_BITS'($urandom), tick_now);
                sent++;
            end else begin
                zone = ZONE_W'($urandom);
                run = int'(settle_need) + $urandom_range(6, 1);
                if (run > 24) run = $urandom_range(24, 1);
                for (int k = 0; k < run; k++) begin
                    tick_now = tick_now + TICK_W'($urandom_range(step_max));
                    smp = ($urandom_range(19) == 0) ? sample_for(ZONE_W'($urandom))
                                                    : sample_for(zone);
                    put_sample(line, smp, tick_now);
                    sent++;
                end
            end
        end
    endtask

    // Drop valid, wait for every owed event, then let queued no-event requests drain
    task automatic drain();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        while (events_due != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [THR_W-1:0] n, input logic [THR_W-1:0] u,
                             input logic [THR_W-1:0] l, input logic [CNT_W-1:0] st,
                             input logic [DUR_W-1:0] lp, input logic [DUR_W-1:0] hd,
                             input logic [DUR_W-1:0] rp, input int unsigned step_max,
                             input int unsigned n_items, input bit squeeze, input bit quiet);
        apply_settings(n, u, l, st, lp, hd, rp);
        tick_now = $urandom;
        steady = quiet;
        if (squeeze) hold_req = 1'b1;
        key_runs(n_items, step_max);
        steady = 1'b0;
        drain();
    endtask

    initial begin
        logic [THR_W-1:0] rn, ru, rl;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: one settling sample, short hold times
        apply_settings(RST_NONE_THR, RST_UPPER_THR, RST_LOWER_THR, 8'd1,
                       16'd100, 16'd50, 16'd20);
        // select key: press, a single long press, nothing after it
        put_sample(SEL_LINE, 12'd1000, 32'd0);
        put_sample(SEL_LINE, 12'd2499, 32'd10);
        put_sample(SEL_LINE, 12'd1500, 32'd110);
        put_sample(SEL_LINE, 12'd1500, 32'd400);
        // release on both edges of the no-key band
        put_sample(SEL_LINE, 12'd4095, 32'd410);
        put_sample(SEL_LINE, 12'd3800, 32'd420);
        // other zone on the control line repeats
        put_sample(SEL_LINE, 12'd2500, 32'd430);
        put_sample(SEL_LINE, 12'd3799, 32'd440);
        put_sample(SEL_LINE, 12'd3000, 32'd500);
        // lowest samples, hold time and repeat spacing at their boundaries
        put_sample(2'd1, 12'd0, 32'd1000);
        put_sample(2'd1, 12'd999, 32'd1000);
        put_sample(2'd1, 12'd0, 32'd1049);
        put_sample(2'd1, 12'd0, 32'd1050);
        put_sample(2'd1, 12'd0, 32'd1069);
        put_sample(2'd1, 12'd0, 32'd1070);
        // bouncing across the lower threshold never settles
        put_sample(2'd2, 12'd999, 32'd2000);
        put_sample(2'd2, 12'd1000, 32'd2001);
        put_sample(2'd2, 12'd999, 32'd2002);
        // hold time measured across the tick wrap
        put_sample(2'd3, 12'd2000, 32'hFFFF_FFE0);
        put_sample(2'd3, 12'd2000, 32'hFFFF_FFF0);
        put_sample(2'd3, 12'd2000, 32'h0000_0030);
        drain();

        // Random phases
        run_phase(RST_NONE_THR, RST_UPPER_THR, RST_LOWER_THR, RST_STABLE,
                  RST_LONG, RST_HOLD, RST_REPEAT, 200, 60, 1'b0, 1'b0);
        // zero settling and zero times: an event on nearly every held sample, receiver held off
        run_phase(RST_NONE_THR, RST_UPPER_THR, RST_LOWER_THR, 8'd0,
                  16'd0, 16'd0, 16'd0, 3, 60, 1'b1, 1'b0);
        // thresholds out of order, no idling on either side
        run_phase(12'd1200, 12'd3000, 12'd2000, 8'd1,
                  16'd20, 16'd10, 16'd5, 8, 50, 1'b0, 1'b1);
        // largest settling count: counts build up but never settle
        run_phase(12'd4095, 12'd0, 12'd0, 8'd255,
                  16'd100, 16'd100, 16'd100, 100, 40, 1'b0, 1'b0);
        // lowered settling count with longest hold times
        run_phase(RST_NONE_THR, RST_UPPER_THR, RST_LOWER_THR, 8'd2,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 20000, 60, 1'b0, 1'b0);
        // no-key threshold at zero: every sample reads as released
        run_phase(12'd0, 12'd4095, 12'd4095, 8'd1,
                  16'd10, 16'd10, 16'd10, 10, 20, 1'b0, 1'b0);
        rl = THR_W'($urandom_range(1500));
        ru = THR_W'($urandom_range(3000, 1501));
        rn = THR_W'($urandom_range(SAMPLE_MAX, 3001));
        run_phase(rn, ru, rl, CNT_W'($urandom_range(4)), DUR_W'($urandom_range(300)),
                  DUR_W'($urandom_range(200)), DUR_W'($urandom_range(60)), 50, 80,
                  1'b0, 1'b0);

        if (err_count == 0 && events_due == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hang
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
